[hw/rtl/b2d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_pkg: shared constants and types of the binary to decimal converter
// Holds the widths of the binary word and of the BCD digit row, the
// double-dabble constants and the types passed between the modules.
// ----------------------------------------------------------------------------
package b2d_pkg;

  // Converted binary width and number of decimal digits kept.
  localparam int BIN_WIDTH  = 128;
  localparam int DEC_DIGITS = 39;

  // Width of each half of the input word.
  localparam int IN_W  = 64;
  // Width of one BCD digit.
  localparam int DIG_W = 4;

  // Step counter and digit counter widths.
  localparam int CNT_W = $clog2(BIN_WIDTH + 1);
  localparam int RM_W  = $clog2(DEC_DIGITS + 1);

  // Shift-and-add-3 constants.
  localparam logic [DIG_W-1:0] ADJ_MIN = 4'd5;
  localparam logic [DIG_W-1:0] ADJ_ADD = 4'd3;
  // Largest legal decimal digit.
  localparam logic [DIG_W-1:0] DIG_MAX = 4'd9;

  typedef logic [DIG_W-1:0] digit_t;
  // Index 0 is the least significant digit.
  typedef digit_t [DEC_DIGITS-1:0] bcd_row_t;

  // Finished conversion handed from the converter to the digit emitter.
  typedef struct packed {
    logic     valid;
    bcd_row_t digits;
  } conv_res_t;

endpackage
`default_nettype wire

[hw/rtl/b2d_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_in_if: input channel of the binary to decimal converter
// Carries one 128-bit unsigned value per beat as two 64-bit halves.
// ----------------------------------------------------------------------------
interface b2d_in_if;
  logic                     valid;
  logic                     ready;
  logic [b2d_pkg::IN_W-1:0] value_high;
  logic [b2d_pkg::IN_W-1:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink (input valid, input value_high, input value_low, output ready);
endinterface
`default_nettype wire

[hw/rtl/b2d_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_out_if: output channel of the binary to decimal converter
// Carries one decimal digit per beat, with a flag on the final digit.
// ----------------------------------------------------------------------------
interface b2d_out_if;
  logic                      valid;
  logic                      ready;
  logic [b2d_pkg::DIG_W-1:0] digit;
  logic                      last;

  modport source (output valid, output digit, output last, input ready);
  modport sink (input valid, input digit, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/b2d_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_cell: one BCD digit cell of the double-dabble chain
// Adds three when the digit is five or more, then shifts in the carry from
// the next lower cell and passes its own top bit to the next higher cell.
// ----------------------------------------------------------------------------
module b2d_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clear,
  input  wire logic            step,
  input  wire logic            carry_in,
  output logic                 carry_out,
  output b2d_pkg::digit_t      digit
);

  b2d_pkg::digit_t adj;

  // Correct the digit so that doubling it yields a valid BCD carry.
  always_comb begin
    if (digit >= b2d_pkg::ADJ_MIN) begin
      adj = digit + b2d_pkg::ADJ_ADD;
    end else begin
      adj = digit;
    end
  end

  assign carry_out = adj[b2d_pkg::DIG_W-1];

  // Digit register: cleared at the start of a conversion, shifted on each step.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      digit <= '0;
    end else if (step) begin
      digit <= {adj[b2d_pkg::DIG_W-2:0], carry_in};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/b2d_conv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_conv: double-dabble converter
// Shifts the binary word out most significant bit first into a chain of
// BCD cells, one bit per cycle, and holds the finished digit row until the
// emitter takes it.
// ----------------------------------------------------------------------------
module b2d_conv (
  input  wire logic            clk,
  input  wire logic            rst,
  b2d_in_if.sink               value,
  output b2d_pkg::conv_res_t   res,
  input  wire logic            res_ready
);

  localparam int IN_TOTAL = 2 * b2d_pkg::IN_W;

  logic [b2d_pkg::BIN_WIDTH-1:0]  shreg;
  logic [b2d_pkg::BIN_WIDTH-1:0]  load_word;
  logic [IN_TOTAL-1:0]            in_word;
  logic [b2d_pkg::CNT_W-1:0]      remain;
  logic                           full;
  logic                           busy;
  logic                           accept;
  logic [b2d_pkg::DEC_DIGITS-1:0] carry;
  b2d_pkg::bcd_row_t              digits;

  assign in_word = {value.value_high, value.value_low};

  // Fit the input word to the converted width.
  generate
    if (b2d_pkg::BIN_WIDTH <= IN_TOTAL) begin : g_trunc
      assign load_word = in_word[b2d_pkg::BIN_WIDTH-1:0];
    end else begin : g_ext
      assign load_word = {{(b2d_pkg::BIN_WIDTH - IN_TOTAL){1'b0}}, in_word};
    end
  endgenerate

  assign busy        = (remain != '0);
  assign value.ready = !busy && (!full || res_ready);
  assign accept      = value.valid && value.ready;

  // Step counter and hand-off flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      full   <= 1'b0;
    end else begin
      if (accept) begin
        remain <= b2d_pkg::CNT_W'(b2d_pkg::BIN_WIDTH);
      end else if (busy) begin
        remain <= remain - b2d_pkg::CNT_W'(1);
      end
      if (busy && remain == b2d_pkg::CNT_W'(1)) begin
        full <= 1'b1;
      end else if (full && res_ready) begin
        full <= 1'b0;
      end
    end
  end

  // Binary shift register, most significant bit leaves first.
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= load_word;
    end else if (busy) begin
      shreg <= shreg << 1;
    end
  end

  assign carry[0] = shreg[b2d_pkg::BIN_WIDTH-1];

  // Row of digit cells; the carry out of the top cell is dropped.
  generate
    for (genvar i = 0; i < b2d_pkg::DEC_DIGITS; i++) begin : g_cell
      if (i < b2d_pkg::DEC_DIGITS - 1) begin : g_mid
        b2d_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .clear     (accept),
          .step      (busy),
          .carry_in  (carry[i]),
          .carry_out (carry[i+1]),
          .digit     (digits[i])
        );
      end else begin : g_top
        b2d_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .clear     (accept),
          .step      (busy),
          .carry_in  (carry[i]),
          .carry_out (),
          .digit     (digits[i])
        );
      end
    end
  endgenerate

  assign res.valid  = full;
  assign res.digits = digits;

endmodule
`default_nettype wire

[hw/rtl/b2d_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_emit: decimal digit emitter
// Loads a finished digit row, skips leading zeros one digit per cycle and
// sends the remaining digits most significant first, one per beat.
// ----------------------------------------------------------------------------
module b2d_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b2d_pkg::conv_res_t  res,
  output logic                     res_ready,
  b2d_out_if.source                result
);

  b2d_pkg::bcd_row_t        dig;
  logic [b2d_pkg::RM_W-1:0] remain;
  logic                     active;
  logic                     seen;
  b2d_pkg::digit_t          top;
  logic                     is_last;
  logic                     show;
  logic                     take;
  logic                     fin;
  logic                     load;

  assign top     = dig[b2d_pkg::DEC_DIGITS-1];
  assign is_last = (remain == b2d_pkg::RM_W'(1));

  // A digit is shown once a nonzero digit appeared, or when it is the final one.
  assign show = active && (seen || top != '0 || is_last);
  assign take = show && result.ready;
  assign fin  = take && is_last;

  assign res_ready = !active || fin;
  assign load      = res.valid && res_ready;

  assign result.valid = show;
  assign result.digit = top;
  assign result.last  = is_last;

  // Digit row shifts toward the top on every skipped or sent digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      seen   <= 1'b0;
      remain <= '0;
      dig    <= '0;
    end else if (load) begin
      active <= 1'b1;
      seen   <= 1'b0;
      remain <= b2d_pkg::RM_W'(b2d_pkg::DEC_DIGITS);
      dig    <= res.digits;
    end else if (active && (take || !show)) begin
      dig    <= {dig[b2d_pkg::DEC_DIGITS-2:0], b2d_pkg::digit_t'(0)};
      remain <= remain - b2d_pkg::RM_W'(1);
      if (take) begin
        seen <= 1'b1;
      end
      if (fin) begin
        active <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/binary_to_decimal_128.sv]
`default_nettype none
// Flow: each value beat is converted in the double-dabble chain, handed off to
// the emitter, then leading zeros are skipped before the first digit beat.
// Throughput: the double-dabble cell chain converts one bit per cycle; a new
// value is taken after hand-off; digit output overlaps the next conversion.
// Reset: synchronous, active high; clears all control state, no clearing pass.
// ----------------------------------------------------------------------------
// binary_to_decimal_128: 128-bit unsigned binary to decimal digit stream
// Converts each value by shift-and-add-3 and sends its decimal digits most
// significant first, leading zeros suppressed, with the final digit flagged.
// ----------------------------------------------------------------------------
module binary_to_decimal_128 (
  input  wire logic   clk,
  input  wire logic   rst,
  b2d_in_if.sink      value,
  b2d_out_if.source   result
);

  b2d_pkg::conv_res_t conv_res;
  logic               conv_ready;

  b2d_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .res       (conv_res),
    .res_ready (conv_ready)
  );

  b2d_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res       (conv_res),
    .res_ready (conv_ready),
    .result    (result)
  );

  // Every digit beat carries a legal decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.digit <= b2d_pkg::DIG_MAX)
    else $error("digit beat out of decimal range");

  // A value beat starts a multi-cycle conversion, so input closes next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    value.valid && value.ready |=> !value.ready)
    else $error("value accepted while conversion in progress");

  // A finished row waiting on the emitter keeps the input closed.
  a_hold_while_full: assert property (@(posedge clk) disable iff (rst)
    conv_res.valid && !conv_ready |-> !value.ready)
    else $error("input open while finished row waits");

endmodule
`default_nettype wire
